// ===== rtl/tga_pkg.sv =====
// Shared types and constants for the TGA truecolor decoder.
// Used by tga_front, tga_queue, tga_back and the top level; no dependencies.
`default_nettype none

package tga_pkg;

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// header byte offsets
	localparam logic [4:0] HDR_ID_LEN   = 5'd0;
	localparam logic [4:0] HDR_MAP_TYPE = 5'd1;
	localparam logic [4:0] HDR_IMG_TYPE = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_DEPTH    = 5'd16;
	localparam logic [4:0] HDR_DESC     = 5'd17;

	localparam logic [7:0] IMG_TRUECOLOR = 8'd2;
	localparam logic [7:0] DEPTH_24      = 8'd24;
	localparam logic [7:0] DEPTH_32      = 8'd32;
	localparam logic [7:0] DESC_TOP_BIT  = 8'h20;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_HDR = 3'd1;
	localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
	localparam logic [2:0] ST_BAD_DEPTH = 3'd3;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd4;
	localparam logic [2:0] ST_TRUNC     = 3'd5;

	// result kinds
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// one queued command: a pixel, a status, or a pixel followed by a status
	typedef struct packed {
		logic        has_pixel;
		logic        has_status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [15:0] column;
		logic [15:0] row;
		logic [2:0]  status;
		logic [15:0] image_width;
		logic [15:0] image_height;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tga_front.sv =====
// Front end: accepts file bytes, parses the header, gathers pixel bytes and
// pushes pixel/status commands. Depends on tga_pkg.
`default_nettype none

module tga_front import tga_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_file,
	input  wire logic       q_full,
	output logic            q_push,
	output cmd_t            q_cmd
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_IDSKIP,
		PH_PIXELS,
		PH_DONE,
		PH_ERROR
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [4:0]  hcnt_q, hcnt_d;
	logic [7:0]  id_left_q, id_left_d;
	logic [7:0]  map_type_q, map_type_d;
	logic [7:0]  img_type_q, img_type_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  depth_q, depth_d;
	logic        top_q, top_d;
	logic [1:0]  bip_q, bip_d;
	logic [23:0] hold_q, hold_d;
	logic [15:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [2:0]  err_q, err_d;

	logic        accept;
	logic        pix_emit;
	logic [1:0]  last_idx;
	logic [15:0] col_inc;
	logic [15:0] row_inc;
	logic [15:0] row_out;
	logic [2:0]  hdr_err;
	logic [2:0]  eof_status;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !byte_stall;

	assign last_idx = (depth_q == DEPTH_32) ? 2'd3 : 2'd2;
	assign col_inc  = col_q + 16'd1;
	assign row_inc  = row_q + 16'd1;
	assign row_out  = top_q ? row_q : (height_q - 16'd1 - row_q);

	always_comb begin
		phase_d    = phase_q;
		hcnt_d     = hcnt_q;
		id_left_d  = id_left_q;
		map_type_d = map_type_q;
		img_type_d = img_type_q;
		width_d    = width_q;
		height_d   = height_q;
		depth_d    = depth_q;
		top_d      = top_q;
		bip_d      = bip_q;
		hold_d     = hold_q;
		col_d      = col_q;
		row_d      = row_q;
		err_d      = err_q;
		pix_emit   = 1'b0;
		hdr_err    = ST_OK;

		case (phase_q)
			PH_HEADER: begin
				case (hcnt_q)
					HDR_ID_LEN:    id_left_d = data_byte;
					HDR_MAP_TYPE:  map_type_d = data_byte;
					HDR_IMG_TYPE:  img_type_d = data_byte;
					HDR_WIDTH_LO:  width_d[7:0] = data_byte;
					HDR_WIDTH_HI:  width_d[15:8] = data_byte;
					HDR_HEIGHT_LO: height_d[7:0] = data_byte;
					HDR_HEIGHT_HI: height_d[15:8] = data_byte;
					HDR_DEPTH:     depth_d = data_byte;
					HDR_DESC:      top_d = |(data_byte & DESC_TOP_BIT);
					default: ;
				endcase
				if (hcnt_q < HDR_DESC) begin
					hcnt_d = hcnt_q + 5'd1;
				end else begin
					// check order: type, then depth, then size
					if (map_type_d != 8'd0 || img_type_d != IMG_TRUECOLOR)
						hdr_err = ST_BAD_TYPE;
					else if (depth_d != DEPTH_24 && depth_d != DEPTH_32)
						hdr_err = ST_BAD_DEPTH;
					else if (width_d == 16'd0 || height_d == 16'd0)
						hdr_err = ST_ZERO_SIZE;
					bip_d  = 2'd0;
					hold_d = 24'd0;
					col_d  = 16'd0;
					row_d  = 16'd0;
					if (hdr_err != ST_OK) begin
						err_d   = hdr_err;
						phase_d = PH_ERROR;
					end else begin
						phase_d = (id_left_d != 8'd0) ? PH_IDSKIP : PH_PIXELS;
					end
				end
			end
			PH_IDSKIP: begin
				id_left_d = id_left_q - 8'd1;
				if (id_left_d == 8'd0)
					phase_d = PH_PIXELS;
			end
			PH_PIXELS: begin
				case (bip_q)
					2'd0: hold_d[7:0]   = data_byte;
					2'd1: hold_d[15:8]  = data_byte;
					2'd2: hold_d[23:16] = data_byte;
					default: ;
				endcase
				if (bip_q != last_idx) begin
					bip_d = bip_q + 2'd1;
				end else begin
					pix_emit = 1'b1;
					bip_d    = 2'd0;
					hold_d   = 24'd0;
					col_d    = col_inc;
					if (col_inc == width_q) begin
						col_d = 16'd0;
						row_d = row_inc;
						if (row_inc == height_q)
							phase_d = PH_DONE;
					end
				end
			end
			default: ;
		endcase

		case (phase_d)
			PH_HEADER: eof_status = ST_SHORT_HDR;
			PH_ERROR:  eof_status = err_d;
			PH_DONE:   eof_status = ST_OK;
			default:   eof_status = ST_TRUNC;
		endcase
	end

	// hold_d still carries the gathered B,G,R bytes only before the clear
	logic [23:0] hold_full;
	always_comb begin
		hold_full = hold_q;
		case (bip_q)
			2'd0: hold_full[7:0]   = data_byte;
			2'd1: hold_full[15:8]  = data_byte;
			2'd2: hold_full[23:16] = data_byte;
			default: ;
		endcase
	end

	assign q_push = accept && (pix_emit || end_of_file);

	always_comb begin
		q_cmd              = '0;
		q_cmd.has_pixel    = pix_emit;
		q_cmd.has_status   = end_of_file;
		q_cmd.red          = hold_full[23:16];
		q_cmd.green        = hold_full[15:8];
		q_cmd.blue         = hold_full[7:0];
		q_cmd.alpha        = (last_idx == 2'd3) ? data_byte : ALPHA_OPAQUE;
		q_cmd.column       = col_q;
		q_cmd.row          = row_out;
		q_cmd.status       = eof_status;
		q_cmd.image_width  = width_d;
		q_cmd.image_height = height_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hcnt_q     <= '0;
			id_left_q  <= '0;
			map_type_q <= '0;
			img_type_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			top_q      <= 1'b0;
			bip_q      <= '0;
			hold_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
			err_q      <= '0;
		end else if (accept) begin
			if (end_of_file) begin
				// file ends: back to reset state for the next file
				phase_q    <= PH_HEADER;
				hcnt_q     <= '0;
				id_left_q  <= '0;
				map_type_q <= '0;
				img_type_q <= '0;
				width_q    <= '0;
				height_q   <= '0;
				depth_q    <= '0;
				top_q      <= 1'b0;
				bip_q      <= '0;
				hold_q     <= '0;
				col_q      <= '0;
				row_q      <= '0;
				err_q      <= '0;
			end else begin
				phase_q    <= phase_d;
				hcnt_q     <= hcnt_d;
				id_left_q  <= id_left_d;
				map_type_q <= map_type_d;
				img_type_q <= img_type_d;
				width_q    <= width_d;
				height_q   <= height_d;
				depth_q    <= depth_d;
				top_q      <= top_d;
				bip_q      <= bip_d;
				hold_q     <= hold_d;
				col_q      <= col_d;
				row_q      <= row_d;
				err_q      <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tga_queue.sv =====
// Small command FIFO between the front end and the result stage.
// Depends on tga_pkg (cmd_t, QDEPTH).
`default_nettype none

module tga_queue import tga_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign empty   = (count_q == QCNT_W'(0));
	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tga_back.sv =====
// Result stage: expands queued commands into pixel and status results and
// holds them in the output register. Depends on tga_pkg.
`default_nettype none

module tga_back import tga_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   head,
	input  wire logic   q_empty,
	output logic        q_pop,
	output logic        result_valid,
	input  wire logic   result_stall,
	output logic        kind,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [15:0] column,
	output logic [15:0] row,
	output logic [2:0]  status,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic        last_of_item
);

	logic        valid_q;
	logic        second_q;   // pixel of a pixel+status command already sent
	logic        load;
	logic        send_pixel;
	logic        kind_q;
	logic [7:0]  red_q, green_q, blue_q, alpha_q;
	logic [15:0] column_q, row_q, width_q, height_q;
	logic [2:0]  status_q;
	logic        last_q;

	assign load       = !q_empty && (!valid_q || !result_stall);
	assign send_pixel = head.has_pixel && !second_q;
	assign q_pop      = load && !(send_pixel && head.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= send_pixel && head.has_status;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			width_q  <= head.image_width;
			height_q <= head.image_height;
			if (send_pixel) begin
				kind_q   <= KIND_PIXEL;
				red_q    <= head.red;
				green_q  <= head.green;
				blue_q   <= head.blue;
				alpha_q  <= head.alpha;
				column_q <= head.column;
				row_q    <= head.row;
				status_q <= ST_OK;
				last_q   <= !head.has_status;
			end else begin
				kind_q   <= KIND_STATUS;
				red_q    <= '0;
				green_q  <= '0;
				blue_q   <= '0;
				alpha_q  <= '0;
				column_q <= '0;
				row_q    <= '0;
				status_q <= head.status;
				last_q   <= 1'b1;
			end
		end
	end

	assign result_valid = valid_q;
	assign kind         = kind_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign alpha        = alpha_q;
	assign column       = column_q;
	assign row          = row_q;
	assign status       = status_q;
	assign image_width  = width_q;
	assign image_height = height_q;
	assign last_of_item = last_q;

endmodule

`default_nettype wire

// ===== rtl/tga_truecolor_to_rgba_decoder.sv =====
// TGA truecolor decoder, top level.
// Byte channel: byte_valid/byte_stall carry one file byte (data_byte) per
// transfer; end_of_file marks the last byte of a file. The next byte after
// it starts a new file.
// Result channel: result_valid/result_stall carry one result per transfer:
// an RGBA pixel with column and destination row (kind 0), or the status of
// the file (kind 1) after its final byte. last_of_item marks the last result
// caused by a byte.
// Throughput: one byte per cycle while byte_stall is low. A byte that ends
// a pixel is written into the 4-entry command queue at its transfer edge
// and its result is offered from the output register once the queue ahead
// is empty and the output register is not stalled. A final byte that also
// ends a pixel yields two results, pixel then status, from one queue entry.
// Reset: arst_n clears the parser to the start of a header and empties the
// queue and output register.
// Stall: the output register holds while result_stall is high; bytes are
// taken until the command queue is full, then byte_stall rises.
`default_nettype none

module tga_truecolor_to_rgba_decoder import tga_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_file,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic            kind,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic [7:0]      alpha,
	output logic [15:0]     column,
	output logic [15:0]     row,
	output logic [2:0]      status,
	output logic [15:0]     image_width,
	output logic [15:0]     image_height,
	output logic            last_of_item
);

	cmd_t push_cmd;
	cmd_t head;
	logic q_push;
	logic q_pop;
	logic q_empty;
	logic q_full;

	tga_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.data_byte   (data_byte),
		.end_of_file (end_of_file),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	tga_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	tga_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.alpha        (alpha),
		.column       (column),
		.row          (row),
		.status       (status),
		.image_width  (image_width),
		.image_height (image_height),
		.last_of_item (last_of_item)
	);

	// a status result always closes its byte's results
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_STATUS |-> last_of_item)
		else $error("status result not marked last");

	a_pixel_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_PIXEL |-> status == ST_OK)
		else $error("pixel result carries nonzero status");

	a_pixel_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_PIXEL |-> column < image_width && row < image_height)
		else $error("pixel position outside image");

	// queue full blocks further input transfers
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> byte_stall)
		else $error("byte accepted with queue full");

endmodule

`default_nettype wire
